FILE: hw/rtl/posting_token_varint_encoder_macros.svh
// assertion macros used by the posting token encoder back end
`ifndef POSTING_TOKEN_VARINT_ENCODER_MACROS_SVH
`define POSTING_TOKEN_VARINT_ENCODER_MACROS_SVH

// concurrent check on a given clock, off while reset is low
`define PTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the usual clock and reset names
`define PTE_CHECK(lbl, prop, msg) \
  `PTE_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/pte_pkg.sv
// shared types and constants of the posting token varint encoder
`default_nettype none

package pte_pkg;

  localparam int VOCAB_DEPTH = 4096;
  localparam int IDX_W       = $clog2(VOCAB_DEPTH);

  localparam int TERM_W  = 12;
  localparam int DOC_W   = 32;
  localparam int POS_W   = 32;
  localparam int LIVE_W  = 13;
  localparam int VOCAB_W = 13;
  localparam int CODE_W  = 8;
  localparam int SH_W    = POS_W + 1;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [VOCAB_W-1:0] VOCAB_RESET = VOCAB_W'(4096);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITIONS = 1'b0,
    CFG_VOCAB     = 1'b1
  } cfg_idx_e;

  // classified token waiting between front and back
  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic [DOC_W-1:0]  doc;
    logic [POS_W-1:0]  pos;
    logic              pos_en;
    logic              bad;
  } token_t;

  // one row of the per-term table
  typedef struct packed {
    logic             started;
    logic             in_order;
    logic [DOC_W-1:0] last_doc;
  } tbl_t;

  typedef struct packed {
    logic [TERM_W-1:0] out_term;
    logic [CODE_W-1:0] code_byte;
    logic              last_byte;
    logic              first_touch;
    logic              starts_doc;
    logic              out_of_order;
    logic              status;
    logic [LIVE_W-1:0] live_terms;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pte_front.sv
// input side: config registers, range check and the token queue
`default_nettype none

module pte_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pte_pkg::TERM_W-1:0]    term_id_i,
  input  wire logic [pte_pkg::DOC_W-1:0]     doc_id_i,
  input  wire logic [pte_pkg::POS_W-1:0]     token_pos_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pte_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pte_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          clr_busy_i,
  output logic                               q_valid_o,
  output pte_pkg::token_t                    q_head_o,
  input  wire logic                          deq_i
);
  import pte_pkg::*;

  logic               pos_en_q;
  logic [VOCAB_W-1:0] vocab_q;

  token_t             fifo_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  logic   enq;
  logic   deq;
  token_t tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_en_q <= 1'b1;
      vocab_q  <= VOCAB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POSITIONS: pos_en_q <= cfg_data_i[0];
        CFG_VOCAB:     vocab_q  <= cfg_data_i[VOCAB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tok.term   = term_id_i;
    tok.doc    = doc_id_i;
    tok.pos    = token_pos_i;
    tok.pos_en = pos_en_q;
    tok.bad    = (VOCAB_W'(term_id_i) >= vocab_q) || (32'(term_id_i) >= 32'(VOCAB_DEPTH));
  end

  // no items while the term table is being cleared
  assign full      = (cnt_q == QCNT_W'(QDEPTH)) || clr_busy_i;
  assign enq       = push && !full;
  assign q_valid_o = (cnt_q != '0);
  assign deq       = deq_i && q_valid_o;
  assign q_head_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_ptr_q] <= tok;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pte_back.sv
// execution side: term table, varint byte sequencer and result register
`default_nettype none

`include "posting_token_varint_encoder_macros.svh"

module pte_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire pte_pkg::token_t q_head_i,
  output logic                 deq_o,
  output logic                 clr_busy_o,
  output logic                 res_valid_o,
  output pte_pkg::res_t        res_o,
  input  wire logic            pop
);
  import pte_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_ERR
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  token_t            item_q, item_d;
  logic [SH_W-1:0]   vsh_q, vsh_d;
  logic [SH_W-1:0]   zsh_q, zsh_d;
  logic              new_doc_q, new_doc_d;
  logic              first_q, first_d;
  logic              ooo_q, ooo_d;
  logic [LIVE_W-1:0] live_q, live_d;
  logic              ov_q, ov_d;
  res_t              res_q, res_d;

  tbl_t              tbl_mem [VOCAB_DEPTH];
  tbl_t              rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  tbl_t              mem_wd;

  logic              slot_free;
  logic              started;
  logic              new_doc;
  logic              in_order_n;
  logic [DOC_W-1:0]  base;
  logic [DOC_W-1:0]  diff_fwd;
  logic [DOC_W-1:0]  diff_bwd;
  logic [SH_W-1:0]   zval;
  logic              v_more;
  logic              z_more;

  assign rd_addr = IDX_W'(q_head_i.term);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    rd_q <= tbl_mem[rd_addr];
  end

  assign slot_free = !ov_q || pop;

  // lookup arithmetic on the registered table row
  always_comb begin
    started    = rd_q.started;
    new_doc    = !started || (rd_q.last_doc != item_q.doc);
    base       = started ? rd_q.last_doc : '0;
    diff_fwd   = item_q.doc - base;
    diff_bwd   = base - item_q.doc;
    // zigzag of the signed delta
    zval       = (item_q.doc >= base) ? {diff_fwd, 1'b0} : ({diff_bwd, 1'b0} - SH_W'(1));
    in_order_n = rd_q.in_order && !(started && (item_q.doc < rd_q.last_doc));
  end

  assign v_more = |vsh_q[SH_W-1:7];
  assign z_more = |zsh_q[SH_W-1:7];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    vsh_d     = vsh_q;
    zsh_d     = zsh_q;
    new_doc_d = new_doc_q;
    first_d   = first_q;
    ooo_d     = ooo_q;
    live_d    = live_q;
    ov_d      = ov_q && !pop;
    res_d     = res_q;
    deq_o     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = IDX_W'(item_q.term);
    mem_wd    = '{started: 1'b1, in_order: in_order_n, last_doc: item_q.doc};

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '{started: 1'b0, in_order: 1'b1, last_doc: '0};
        clr_d  = clr_q + 1'b1;
        if (clr_q == IDX_W'(VOCAB_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          deq_o   = 1'b1;
          item_d  = q_head_i;
          state_d = q_head_i.bad ? ST_ERR : ST_LOOK;
        end
      end
      ST_LOOK: begin
        first_d   = !started;
        new_doc_d = new_doc;
        ooo_d     = !in_order_n;
        if (!started && (live_q != '1)) begin
          live_d = live_q + 1'b1;
        end
        vsh_d   = item_q.pos_en ? {item_q.pos, new_doc} : SH_W'(new_doc);
        zsh_d   = zval;
        mem_we  = new_doc;
        state_d = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (slot_free) begin
          ov_d               = 1'b1;
          res_d.out_term     = item_q.term;
          res_d.code_byte    = {v_more, vsh_q[6:0]};
          res_d.last_byte    = !v_more && !new_doc_q;
          res_d.first_touch  = first_q;
          res_d.starts_doc   = new_doc_q;
          res_d.out_of_order = ooo_q;
          res_d.status       = 1'b0;
          res_d.live_terms   = live_q;
          vsh_d              = vsh_q >> 7;
          if (!v_more) begin
            state_d = new_doc_q ? ST_EMIT_B : ST_IDLE;
          end
        end
      end
      ST_EMIT_B: begin
        if (slot_free) begin
          ov_d               = 1'b1;
          res_d.out_term     = item_q.term;
          res_d.code_byte    = {z_more, zsh_q[6:0]};
          res_d.last_byte    = !z_more;
          res_d.first_touch  = first_q;
          res_d.starts_doc   = 1'b1;
          res_d.out_of_order = ooo_q;
          res_d.status       = 1'b0;
          res_d.live_terms   = live_q;
          zsh_d              = zsh_q >> 7;
          if (!z_more) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          ov_d               = 1'b1;
          res_d.out_term     = item_q.term;
          res_d.code_byte    = '0;
          res_d.last_byte    = 1'b1;
          res_d.first_touch  = 1'b0;
          res_d.starts_doc   = 1'b0;
          res_d.out_of_order = 1'b0;
          res_d.status       = 1'b1;
          res_d.live_terms   = live_q;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      item_q    <= '0;
      vsh_q     <= '0;
      zsh_q     <= '0;
      new_doc_q <= 1'b0;
      first_q   <= 1'b0;
      ooo_q     <= 1'b0;
      live_q    <= '0;
      ov_q      <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      item_q    <= item_d;
      vsh_q     <= vsh_d;
      zsh_q     <= zsh_d;
      new_doc_q <= new_doc_d;
      first_q   <= first_d;
      ooo_q     <= ooo_d;
      live_q    <= live_d;
      ov_q      <= ov_d;
      res_q     <= res_d;
    end
  end

  assign clr_busy_o  = (state_q == ST_CLEAR);
  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  `PTE_CHECK(a_no_deq_in_clear, (state_q == ST_CLEAR) |-> !deq_o, "token taken during clear")
  `PTE_CHECK(a_deq_starts_item, deq_o |=> (state_q == ST_LOOK || state_q == ST_ERR),
             "dequeue did not start an item")
  `PTE_CHECK(a_look_after_idle, (state_q == ST_LOOK) |-> ($past(state_q) == ST_IDLE),
             "lookup without a fresh read")
  `PTE_CHECK(a_write_states, mem_we |-> (state_q == ST_CLEAR || state_q == ST_LOOK),
             "table written outside clear or lookup")

endmodule

`default_nettype wire

FILE: hw/rtl/posting_token_varint_encoder.sv
// Posting token varint encoder: top level.
// Tokens (term_id, doc_id, token_pos) enter through push/full; an item is
// taken at a clock edge with push high and full low. Result bytes leave
// through empty/pop, one item per varint byte, oldest first, last_byte set
// on the final byte of a token. The two configuration registers are to be
// written through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is
// idle; the user must keep to this, the block does not enforce it. After
// reset the per-term table is cleared one row a cycle, all 4096 rows,
// while full stays high; then tokens are taken. A token waits in a
// two-entry queue; the back end dequeues it and reads the term's table
// row, computes the entry and delta and then sends one byte a cycle while
// the receiver pops. A token gives 1 to 10 bytes, a rejected term id a
// single error byte. The back end takes a new token only after the last
// byte of the previous one has gone into the output register.
// When the receiver does not pop, the byte sequencer halts on the held
// result and the queue fills, then full rises.
`default_nettype none

module posting_token_varint_encoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pte_pkg::TERM_W-1:0]    term_id_i,
  input  wire logic [pte_pkg::DOC_W-1:0]     doc_id_i,
  input  wire logic [pte_pkg::POS_W-1:0]     token_pos_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pte_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pte_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [pte_pkg::TERM_W-1:0]         out_term_o,
  output logic [pte_pkg::CODE_W-1:0]         code_byte_o,
  output logic                               last_byte_o,
  output logic                               first_touch_o,
  output logic                               starts_doc_o,
  output logic                               out_of_order_o,
  output logic                               status_o,
  output logic [pte_pkg::LIVE_W-1:0]         live_terms_o
);
  import pte_pkg::*;

  logic   q_valid;
  token_t q_head;
  logic   deq;
  logic   clr_busy;
  logic   res_valid;
  res_t   res;

  pte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .term_id_i   (term_id_i),
    .doc_id_i    (doc_id_i),
    .token_pos_i (token_pos_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .clr_busy_i  (clr_busy),
    .q_valid_o   (q_valid),
    .q_head_o    (q_head),
    .deq_i       (deq)
  );

  pte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .deq_o       (deq),
    .clr_busy_o  (clr_busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pop         (pop)
  );

  assign empty          = !res_valid;
  assign out_term_o     = res.out_term;
  assign code_byte_o    = res.code_byte;
  assign last_byte_o    = res.last_byte;
  assign first_touch_o  = res.first_touch;
  assign starts_doc_o   = res.starts_doc;
  assign out_of_order_o = res.out_of_order;
  assign status_o       = res.status;
  assign live_terms_o   = res.live_terms;

endmodule

`default_nettype wire

FILE: verif/posting_token_varint_encoder_test.sv
// self-checking testbench of the posting token varint encoder
`timescale 1ns / 100ps

module posting_token_varint_encoder_test;
  import pte_pkg::*;

  typedef struct {
    logic              is_cfg;
    cfg_idx_e          reg_sel;
    logic [CFG_W-1:0]  reg_val;
    logic [TERM_W-1:0] term;
    logic [DOC_W-1:0]  doc;
    logic [POS_W-1:0]  pos;
    int                n_typed;
    res_t              typed0;
    res_t              typed1;
  } step_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [TERM_W-1:0]    term_id_i = '0;
  logic [DOC_W-1:0]     doc_id_i = '0;
  logic [POS_W-1:0]     token_pos_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [TERM_W-1:0]    out_term_o;
  logic [CODE_W-1:0]    code_byte_o;
  logic                 last_byte_o;
  logic                 first_touch_o;
  logic                 starts_doc_o;
  logic                 out_of_order_o;
  logic                 status_o;
  logic [LIVE_W-1:0]    live_terms_o;

  // encoder image kept by the testbench
  logic              started_tbl [VOCAB_DEPTH];
  logic [DOC_W-1:0]  last_doc_tbl [VOCAB_DEPTH];
  logic              in_order_tbl [VOCAB_DEPTH];
  logic [LIVE_W-1:0] touched_terms = '0;
  logic              pos_tag_en = 1'b1;
  logic [VOCAB_W-1:0] vocab_limit = VOCAB_RESET;

  res_t owed_bytes[$];
  int   fails = 0;
  int   tokens_taken = 0;
  int   bytes_seen = 0;
  logic hold_rx = 1'b0;

  posting_token_varint_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .term_id_i      (term_id_i),
    .doc_id_i       (doc_id_i),
    .token_pos_i    (token_pos_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .empty          (empty),
    .pop            (pop),
    .out_term_o     (out_term_o),
    .code_byte_o    (code_byte_o),
    .last_byte_o    (last_byte_o),
    .first_touch_o  (first_touch_o),
    .starts_doc_o   (starts_doc_o),
    .out_of_order_o (out_of_order_o),
    .status_o       (status_o),
    .live_terms_o   (live_terms_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void append_leb128(inout logic [7:0] seq[$], input logic [63:0] v);
    while (v >= 64'h80) begin
      seq.insert(seq.size(), {1'b1, v[6:0]});
      v = v >> 7;
    end
    seq.insert(seq.size(), {1'b0, v[6:0]});
  endfunction

  // bytes one token adds to its posting chain, table updated on the way
  function automatic void encode_token(input logic [TERM_W-1:0] t, input logic [DOC_W-1:0] d,
                                       input logic [POS_W-1:0] p, output res_t enc[$]);
    logic [7:0]       seq[$];
    logic             first;
    logic             fresh;
    logic [DOC_W-1:0] base;
    logic [63:0]      z;
    enc = {};
    if ({1'b0, t} >= vocab_limit || int'(t) >= VOCAB_DEPTH) begin
      enc.insert(enc.size(), '{out_term: t, code_byte: 8'h00, last_byte: 1'b1,
                               first_touch: 1'b0, starts_doc: 1'b0, out_of_order: 1'b0,
                               status: 1'b1, live_terms: touched_terms});
      return;
    end
    first = !started_tbl[t];
    if (first && touched_terms != '1) touched_terms = touched_terms + 1'b1;
    fresh = first || last_doc_tbl[t] != d;
    if (pos_tag_en) append_leb128(seq, {31'b0, p, fresh});
    else append_leb128(seq, {63'b0, fresh});
    if (fresh) begin
      base = first ? '0 : last_doc_tbl[t];
      if (!first && d < base) in_order_tbl[t] = 1'b0;
      // zigzag of the signed doc delta
      if (d >= base) z = {31'b0, d - base, 1'b0};
      else z = {31'b0, base - d, 1'b0} - 64'd1;
      append_leb128(seq, z);
      last_doc_tbl[t] = d;
      started_tbl[t] = 1'b1;
    end
    foreach (seq[k]) begin
      enc.insert(enc.size(), '{out_term: t, code_byte: seq[k], last_byte: k == seq.size() - 1,
                               first_touch: first, starts_doc: fresh,
                               out_of_order: !in_order_tbl[t], status: 1'b0,
                               live_terms: touched_terms});
    end
  endfunction

  function automatic step_row_t tok(logic [TERM_W-1:0] t, logic [DOC_W-1:0] d,
                                    logic [POS_W-1:0] p);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.reg_sel = CFG_POSITIONS;
    row.reg_val = '0;
    row.term = t;
    row.doc = d;
    row.pos = p;
    row.n_typed = 0;
    row.typed0 = '0;
    row.typed1 = '0;
    return row;
  endfunction

  function automatic step_row_t set_reg(cfg_idx_e sel, logic [CFG_W-1:0] val);
    step_row_t row;
    row = tok('0, '0, '0);
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // rejected term id: one error item, nothing else moves
  function automatic step_row_t bad_tok(logic [TERM_W-1:0] t, logic [LIVE_W-1:0] live);
    step_row_t row;
    row = tok(t, 32'h1234_5678, 32'h0000_0042);
    row.n_typed = 1;
    row.typed0 = '{out_term: t, code_byte: 8'h00, last_byte: 1'b1, first_touch: 1'b0,
                   starts_doc: 1'b0, out_of_order: 1'b0, status: 1'b1, live_terms: live};
    return row;
  endfunction

  task automatic offer_token(input step_row_t row);
    res_t enc[$];
    while (!(tokens_taken >= 100 && tokens_taken < 150) && $urandom_range(0, 99) < 11) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    term_id_i <= row.term;
    doc_id_i <= row.doc;
    token_pos_i <= row.pos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tokens_taken++;
    encode_token(row.term, row.doc, row.pos, enc);
    if (row.n_typed > 0) owed_bytes.insert(owed_bytes.size(), row.typed0);
    if (row.n_typed > 1) owed_bytes.insert(owed_bytes.size(), row.typed1);
    if (row.n_typed == 0) owed_bytes = {owed_bytes, enc};
  endtask

  // wait until every byte is out and the back end has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e sel, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (sel)
      CFG_POSITIONS: pos_tag_en = val[0];
      CFG_VOCAB:     vocab_limit = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_byte(input res_t got);
    res_t want;
    if (owed_bytes.size() == 0) begin
      $error("unexpected item: term %0h byte %0h", got.out_term, got.code_byte);
      fails++;
      return;
    end
    want = owed_bytes.pop_front();
    if (got.out_term !== want.out_term) begin
      $error("out_term: expected %0h, got %0h", want.out_term, got.out_term);
      fails++;
    end
    if (got.code_byte !== want.code_byte) begin
      $error("code_byte: expected %0h, got %0h", want.code_byte, got.code_byte);
      fails++;
    end
    if (got.last_byte !== want.last_byte) begin
      $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
      fails++;
    end
    if (got.first_touch !== want.first_touch) begin
      $error("first_touch: expected %0b, got %0b", want.first_touch, got.first_touch);
      fails++;
    end
    if (got.starts_doc !== want.starts_doc) begin
      $error("starts_doc: expected %0b, got %0b", want.starts_doc, got.starts_doc);
      fails++;
    end
    if (got.out_of_order !== want.out_of_order) begin
      $error("out_of_order: expected %0b, got %0b", want.out_of_order, got.out_of_order);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0b, got %0b", want.status, got.status);
      fails++;
    end
    if (got.live_terms !== want.live_terms) begin
      $error("live_terms: expected %0d, got %0d", want.live_terms, got.live_terms);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        check_byte('{out_term: out_term_o, code_byte: code_byte_o, last_byte: last_byte_o,
                     first_touch: first_touch_o, starts_doc: starts_doc_o,
                     out_of_order: out_of_order_o, status: status_o,
                     live_terms: live_terms_o});
        bytes_seen++;
      end
      pop <= !hold_rx && ((bytes_seen >= 300 && bytes_seen < 600) ||
                          $urandom_range(0, 99) >= 11);
    end
  end

  // long receiver stall so the token queue backs up into full
  initial begin
    wait (tokens_taken >= 40);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("posting_token_varint_encoder_test: FAIL");
    $finish;
  end

  initial begin
    step_row_t         plan[$];
    step_row_t         row;
    logic [TERM_W-1:0] term_pool [8];
    logic [DOC_W-1:0]  doc_cursor;
    logic [TERM_W-1:0] t;
    logic [DOC_W-1:0]  d;
    logic [POS_W-1:0]  p;
    int                r;
    for (int i = 0; i < VOCAB_DEPTH; i++) begin
      started_tbl[i] = 1'b0;
      last_doc_tbl[i] = '0;
      in_order_tbl[i] = 1'b1;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // table clearing pass after reset
    @(posedge clk_i);
    while (full) @(posedge clk_i);

    // first token after reset: entry 1, delta 0
    row = tok(12'd0, 32'd0, 32'd0);
    row.n_typed = 2;
    row.typed0 = '{out_term: 12'd0, code_byte: 8'h01, last_byte: 1'b0, first_touch: 1'b1,
                   starts_doc: 1'b1, out_of_order: 1'b0, status: 1'b0, live_terms: 13'd1};
    row.typed1 = '{out_term: 12'd0, code_byte: 8'h00, last_byte: 1'b1, first_touch: 1'b1,
                   starts_doc: 1'b1, out_of_order: 1'b0, status: 1'b0, live_terms: 13'd1};
    plan.insert(plan.size(), row);
    plan.insert(plan.size(), tok(12'd0, 32'd0, 32'd5));                   // same document
    plan.insert(plan.size(), tok(12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // ten bytes
    plan.insert(plan.size(), tok(12'hFFF, 32'd0, 32'd0));                 // docs go backwards
    plan.insert(plan.size(), tok(12'hFFF, 32'd1, 32'd1));
    plan.insert(plan.size(), tok(12'd1, 32'd100, 32'd63));
    plan.insert(plan.size(), tok(12'd1, 32'd100, 32'd64));
    plan.insert(plan.size(), tok(12'd2, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.insert(plan.size(), set_reg(CFG_VOCAB, 13'd0));
    plan.insert(plan.size(), bad_tok(12'd0, 13'd4));
    plan.insert(plan.size(), bad_tok(12'hFFF, 13'd4));
    plan.insert(plan.size(), set_reg(CFG_VOCAB, 13'd1));
    plan.insert(plan.size(), tok(12'd0, 32'd7, 32'd3));                   // valid after an error
    plan.insert(plan.size(), bad_tok(12'd1, 13'd4));
    plan.insert(plan.size(), set_reg(CFG_VOCAB, 13'h1FFF));               // register above depth
    plan.insert(plan.size(), tok(12'hFFF, 32'd2, 32'd2));
    plan.insert(plan.size(), set_reg(CFG_POSITIONS, 13'd0));
    plan.insert(plan.size(), tok(12'd3, 32'd9, 32'd1234));
    plan.insert(plan.size(), tok(12'd3, 32'd9, 32'd9));
    plan.insert(plan.size(), tok(12'd3, 32'd8, 32'd0));
    plan.insert(plan.size(), set_reg(CFG_POSITIONS, 13'd1));
    plan.insert(plan.size(), set_reg(CFG_VOCAB, VOCAB_RESET));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        offer_token(plan[i]);
      end
    end

    foreach (term_pool[i]) term_pool[i] = TERM_W'($urandom_range(0, 31));
    doc_cursor = $urandom_range(0, 1000);
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_POSITIONS, 13'd1);
          write_reg(CFG_VOCAB, VOCAB_RESET);
        end
        1: begin
          write_reg(CFG_POSITIONS, 13'd0);
          write_reg(CFG_VOCAB, CFG_W'($urandom_range(0, 4096)));
        end
        2: begin
          write_reg(CFG_POSITIONS, 13'd1);
          write_reg(CFG_VOCAB, CFG_W'($urandom_range(1, 300)));
        end
        3: begin
          write_reg(CFG_POSITIONS, 13'd1);
          write_reg(CFG_VOCAB, 13'h1FFF);
        end
        default: begin
          write_reg(CFG_POSITIONS, 13'd0);
          write_reg(CFG_VOCAB, VOCAB_RESET);
        end
      endcase
      for (int n = 0; n < 41; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // posting stream: few terms, mostly rising docs, repeats within a doc
          t = term_pool[$urandom_range(0, 7)];
          if ($urandom_range(0, 3) == 0) doc_cursor += $urandom_range(1, 50);
          if ($urandom_range(0, 19) == 0) doc_cursor += $urandom;
          d = doc_cursor;
          p = $urandom_range(0, 400);
        end else if (r < 85) begin
          t = TERM_W'($urandom);
          d = $urandom;
          p = $urandom;
        end else begin
          t = term_pool[$urandom_range(0, 7)];
          d = doc_cursor - $urandom_range(1, 1000);
          p = $urandom;
        end
        offer_token(tok(t, d, p));
      end
    end

    push <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("posting_token_varint_encoder_test: PASS");
    end else begin
      $display("posting_token_varint_encoder_test: FAIL");
    end
    $finish;
  end

endmodule
